### rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Timed task schedule queue package
// Shared widths, default sizes, operation codes, sequencer states and the
// request/response types of the shared time arithmetic unit.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Default sizes
  localparam int unsigned TTS_QUEUE_DEPTH = 16;
  localparam int unsigned TTS_ID_BITS     = 8;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DELAY_W = 32;

  // Saturation limits of a due time
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_ZERO = '0;

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 2'd0,
    OP_PULL       = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_SET_ENABLE = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HEAD,
    ST_ENA,
    ST_WALK,
    ST_PLACE,
    ST_DONE
  } state_e;

  // Time unit modes
  typedef enum logic [1:0] {
    TU_ADD    = 2'd0,
    TU_MINDEC = 2'd1,
    TU_GT     = 2'd2
  } tu_mode_e;

  typedef struct packed {
    tu_mode_e          mode;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } tu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] result;
    logic              gt;
  } tu_rsp_t;

endpackage

### rtl/tts_task_if.sv
// ----------------------------------------------------------------------------
// Task item channel
// Valid/ready channel that carries one scheduling command per beat.
// ----------------------------------------------------------------------------
interface tts_task_if
  import tts_pkg::*;
#(
  parameter int unsigned ID_BITS = TTS_ID_BITS
) ();

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [TIME_W-1:0]  reference_time;
  logic [DELAY_W-1:0] delay_ms;
  logic               to_front;
  logic [ID_BITS-1:0] task_id;
  logic               repeat_req;
  logic               enable_value;

  modport source (
    output valid, operation, reference_time, delay_ms, to_front, task_id,
           repeat_req, enable_value,
    input  ready
  );

  modport sink (
    input  valid, operation, reference_time, delay_ms, to_front, task_id,
           repeat_req, enable_value,
    output ready
  );

endinterface

### rtl/tts_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat per task item.
// ----------------------------------------------------------------------------
interface tts_result_if
  import tts_pkg::*;
#(
  parameter int unsigned ID_BITS     = TTS_ID_BITS,
  parameter int unsigned QUEUE_DEPTH = TTS_QUEUE_DEPTH
) ();

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic               valid;
  logic               ready;
  logic               task_valid;
  logic [ID_BITS-1:0] popped_task;
  logic [TIME_W-1:0]  last_timestamp;
  logic               queue_empty;
  logic               push_dropped;
  logic [CNT_W-1:0]   entry_count;

  modport source (
    output valid, task_valid, popped_task, last_timestamp, queue_empty,
           push_dropped, entry_count,
    input  ready
  );

  modport sink (
    input  valid, task_valid, popped_task, last_timestamp, queue_empty,
           push_dropped, entry_count,
    output ready
  );

endinterface

### rtl/tts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on a
// read of the address written in the same cycle).
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tts_time_unit.sv
// ----------------------------------------------------------------------------
// Time arithmetic unit
// One comparator and one adder shared by every step of the sequencer:
// saturating add, min-minus-one held at zero, and greater-than.
// ----------------------------------------------------------------------------
module tts_time_unit
  import tts_pkg::*;
(
  input  tu_req_t req_i,
  output tu_rsp_t rsp_o
);

  logic              a_gt_b;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] min_ab;

  // Compare once, reuse for the min
  assign a_gt_b = req_i.a > req_i.b;
  assign min_ab = a_gt_b ? req_i.b : req_i.a;
  assign sum    = {1'b0, req_i.a} + {1'b0, req_i.b};

  // Select the result of the mode
  always_comb begin
    rsp_o.gt = a_gt_b;
    case (req_i.mode)
      TU_ADD:    rsp_o.result = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      TU_MINDEC: rsp_o.result = (min_ab == TIME_ZERO) ? TIME_ZERO
                                                      : min_ab - TIME_W'(1);
      TU_GT:     rsp_o.result = min_ab;
      default:   rsp_o.result = TIME_ZERO;
    endcase
  end

endmodule

### rtl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// Schedule queue sequencer
// Circular slot buffer kept sorted by due time. Pops advance the head;
// inserts walk back from the tail one slot a cycle through the slot RAM,
// using the shared time unit for every compare and add.
// ----------------------------------------------------------------------------
module tts_ctrl
  import tts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = TTS_QUEUE_DEPTH,
  parameter int unsigned TASK_ID_BITS = TTS_ID_BITS,
  localparam int unsigned AW     = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned SLOT_W = TIME_W + TASK_ID_BITS + DELAY_W + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tts_task_if.sink                task_in_i,
  tts_result_if.source            result_o,
  // Shared time unit
  output tu_req_t                 tu_req_o,
  input  tu_rsp_t                 tu_rsp_i,
  // Slot RAM
  output logic                    slot_we_o,
  output logic [AW-1:0]           slot_waddr_o,
  output logic [SLOT_W-1:0]       slot_wdata_o,
  output logic [AW-1:0]           slot_raddr_o,
  input  logic [SLOT_W-1:0]       slot_rdata_i,
  // Enable RAM
  output logic                    en_we_o,
  output logic [TASK_ID_BITS-1:0] en_waddr_o,
  output logic                    en_wdata_o,
  output logic [TASK_ID_BITS-1:0] en_raddr_o,
  input  logic                    en_rdata_i
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   WRAP_SUM  = (CW+1)'(QUEUE_DEPTH);

  state_e state_q, state_d;

  // Latched item
  op_e                     op_q, op_d;
  logic [TIME_W-1:0]       ref_q, ref_d;
  logic [DELAY_W-1:0]      delay_q, delay_d;
  logic                    front_q, front_d;
  logic [TASK_ID_BITS-1:0] id_q, id_d;
  logic                    rep_q, rep_d;
  logic                    en_q, en_d;

  // Queue state
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [TIME_W-1:0]       last_q, last_d;
  logic [TASK_ID_BITS-1:0] init_q, init_d;

  // Entry being inserted and walk pointers
  logic [TIME_W-1:0]       ins_due_q, ins_due_d;
  logic [TASK_ID_BITS-1:0] ins_task_q, ins_task_d;
  logic [DELAY_W-1:0]      ins_period_q, ins_period_d;
  logic                    ins_rep_q, ins_rep_d;
  logic [AW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]           left_q, left_d;

  // Item result
  logic                    valid_q, valid_d;
  logic [TASK_ID_BITS-1:0] popped_q, popped_d;
  logic                    dropped_q, dropped_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic                    out_task_valid_q, out_task_valid_d;
  logic [TASK_ID_BITS-1:0] out_popped_q, out_popped_d;
  logic [TIME_W-1:0]       out_last_q, out_last_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_dropped_q, out_dropped_d;
  logic [CW-1:0]           out_count_q, out_count_d;

  // Slot read fields
  logic [TIME_W-1:0]       rd_due;
  logic [TASK_ID_BITS-1:0] rd_task;
  logic [DELAY_W-1:0]      rd_period;
  logic                    rd_rep;

  logic [CW:0]             tail_sum;
  logic [AW-1:0]           tail;
  logic [AW-1:0]           tail_prev;
  logic [AW-1:0]           rd_prev;
  logic                    in_fire;
  logic                    out_free;
  logic                    head_due;
  logic                    walk_move;
  logic [SLOT_W-1:0]       new_slot;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  assign {rd_due, rd_task, rd_period, rd_rep} = slot_rdata_i;
  assign new_slot = {ins_due_q, ins_task_q, ins_period_q, ins_rep_q};

  // Tail slot (one past the last entry) with wrap
  assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail      = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
  assign tail_prev = ptr_dec(tail);
  assign rd_prev   = ptr_dec(rd_ptr_q);

  assign in_fire   = task_in_i.valid && task_in_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;
  assign head_due  = (count_q != '0) && !tu_rsp_i.gt;
  assign walk_move = tu_rsp_i.gt;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        case (op_q)
          OP_PUSH: begin
            if (count_q == FULL_CNT) state_d = ST_DONE;
            else if (count_q == '0)  state_d = ST_PLACE;
            else                     state_d = ST_WALK;
          end
          OP_PULL: begin
            state_d = (head_due && rd_rep) ? ST_ENA : ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_ENA: begin
        if (!en_rdata_i)         state_d = ST_DONE;
        else if (count_q == '0)  state_d = ST_PLACE;
        else                     state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!walk_move)              state_d = ST_DONE;
        else if (left_q == CW'(1))   state_d = ST_PLACE;
      end
      ST_PLACE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Datapath, RAM ports and handshake
  always_comb begin
    op_d         = op_q;
    ref_d        = ref_q;
    delay_d      = delay_q;
    front_d      = front_q;
    id_d         = id_q;
    rep_d        = rep_q;
    en_d         = en_q;
    head_d       = head_q;
    count_d      = count_q;
    last_d       = last_q;
    init_d       = init_q;
    ins_due_d    = ins_due_q;
    ins_task_d   = ins_task_q;
    ins_period_d = ins_period_q;
    ins_rep_d    = ins_rep_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    left_d       = left_q;
    valid_d      = valid_q;
    popped_d     = popped_q;
    dropped_d    = dropped_q;

    out_valid_d      = out_valid_q && !result_o.ready;
    out_task_valid_d = out_task_valid_q;
    out_popped_d     = out_popped_q;
    out_last_d       = out_last_q;
    out_empty_d      = out_empty_q;
    out_dropped_d    = out_dropped_q;
    out_count_d      = out_count_q;

    task_in_i.ready = 1'b0;
    tu_req_o        = '{mode: TU_GT, a: rd_due, b: ref_q};
    slot_we_o       = 1'b0;
    slot_waddr_o    = wr_ptr_q;
    slot_wdata_o    = new_slot;
    slot_raddr_o    = head_q;
    en_we_o         = 1'b0;
    en_waddr_o      = init_q;
    en_wdata_o      = 1'b1;
    en_raddr_o      = rd_task;

    case (state_q)
      // Set every enable bit after reset
      ST_INIT: begin
        en_we_o = 1'b1;
        init_d  = init_q + TASK_ID_BITS'(1);
      end

      // Take a beat; head slot read is in flight
      ST_IDLE: begin
        task_in_i.ready = 1'b1;
        if (in_fire) begin
          op_d      = op_e'(task_in_i.operation);
          ref_d     = task_in_i.reference_time;
          delay_d   = task_in_i.delay_ms;
          front_d   = task_in_i.to_front;
          id_d      = task_in_i.task_id;
          rep_d     = task_in_i.repeat_req;
          en_d      = task_in_i.enable_value;
          valid_d   = 1'b0;
          popped_d  = '0;
          dropped_d = 1'b0;
        end
      end

      // Head slot available: decide the operation
      ST_HEAD: begin
        case (op_q)
          OP_PUSH: begin
            if (front_q) begin
              tu_req_o = '{mode: TU_MINDEC, a: rd_due, b: ref_q};
            end else begin
              tu_req_o = '{mode: TU_ADD, a: ref_q, b: TIME_W'(delay_q)};
            end
            if (count_q == FULL_CNT) begin
              dropped_d = 1'b1;
            end else begin
              ins_due_d    = (front_q && count_q == '0) ? ref_q : tu_rsp_i.result;
              ins_task_d   = id_q;
              ins_period_d = delay_q;
              ins_rep_d    = rep_q && !front_q;
              wr_ptr_d     = tail;
              rd_ptr_d     = tail_prev;
              left_d       = count_q;
              slot_raddr_o = tail_prev;
            end
          end
          OP_PULL: begin
            if (head_due) begin
              head_d       = ptr_inc(head_q);
              count_d      = count_q - CW'(1);
              last_d       = rd_due;
              valid_d      = 1'b1;
              popped_d     = rd_task;
              ins_task_d   = rd_task;
              ins_period_d = rd_period;
              ins_rep_d    = 1'b1;
            end
          end
          OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
            en_we_o    = 1'b1;
            en_waddr_o = id_q;
            en_wdata_o = en_q;
          end
        endcase
      end

      // Enable bit of the popped task is back: reschedule one period on
      ST_ENA: begin
        tu_req_o     = '{mode: TU_ADD, a: last_q, b: TIME_W'(ins_period_q)};
        ins_due_d    = tu_rsp_i.result;
        wr_ptr_d     = tail;
        rd_ptr_d     = tail_prev;
        left_d       = count_q;
        slot_raddr_o = tail_prev;
      end

      // Shift a later entry up one slot, or drop the new one in place
      ST_WALK: begin
        tu_req_o = '{mode: TU_GT, a: rd_due, b: ins_due_q};
        slot_we_o = 1'b1;
        if (walk_move) begin
          slot_wdata_o = slot_rdata_i;
          wr_ptr_d     = rd_ptr_q;
          rd_ptr_d     = rd_prev;
          slot_raddr_o = rd_prev;
          left_d       = left_q - CW'(1);
        end else begin
          count_d = count_q + CW'(1);
        end
      end

      ST_PLACE: begin
        slot_we_o = 1'b1;
        count_d   = count_q + CW'(1);
      end

      // Load the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_task_valid_d = valid_q;
          out_popped_d     = popped_q;
          out_last_d       = last_q;
          out_empty_d      = (count_q == '0);
          out_dropped_d    = dropped_q;
          out_count_d      = count_q;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      head_q      <= '0;
      count_q     <= '0;
      last_q      <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      last_q      <= last_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q             <= op_d;
    ref_q            <= ref_d;
    delay_q          <= delay_d;
    front_q          <= front_d;
    id_q             <= id_d;
    rep_q            <= rep_d;
    en_q             <= en_d;
    ins_due_q        <= ins_due_d;
    ins_task_q       <= ins_task_d;
    ins_period_q     <= ins_period_d;
    ins_rep_q        <= ins_rep_d;
    wr_ptr_q         <= wr_ptr_d;
    rd_ptr_q         <= rd_ptr_d;
    left_q           <= left_d;
    valid_q          <= valid_d;
    popped_q         <= popped_d;
    dropped_q        <= dropped_d;
    out_task_valid_q <= out_task_valid_d;
    out_popped_q     <= out_popped_d;
    out_last_q       <= out_last_d;
    out_empty_q      <= out_empty_d;
    out_dropped_q    <= out_dropped_d;
    out_count_q      <= out_count_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.task_valid     = out_task_valid_q;
  assign result_o.popped_task    = out_popped_q;
  assign result_o.last_timestamp = out_last_q;
  assign result_o.queue_empty    = out_empty_q;
  assign result_o.push_dropped   = out_dropped_q;
  assign result_o.entry_count    = out_count_q;

  // Occupancy never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("entry count above queue depth");

  // An insert walk always has a free slot to move into
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_PLACE) |-> count_q < FULL_CNT)
    else $error("insert started on a full queue");

  // A drop is reported only when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && dropped_q) |-> count_q == FULL_CNT)
    else $error("drop flagged with room left");

  // Placing the new entry grows the queue by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLACE) |=> count_q == $past(count_q) + CW'(1))
    else $error("placement did not grow the queue");

endmodule

### rtl/timed_task_schedule_queue.sv
// ----------------------------------------------------------------------------
// Timed task schedule queue
// Keeps tasks sorted by due time; push, pull-when-due with periodic
// rescheduling, clear, and per-task enable bits.
// ----------------------------------------------------------------------------
// Usage:
//   task_in_i carries one command per beat (push, pull, clear, set enable);
//   result_o returns exactly one result beat per command, in order.
//   The block works on one command at a time and holds task_in_i.ready low
//   until that command's result has been loaded into the output register.
//   Each command is taken in ST_IDLE, decided in ST_HEAD and finished in
//   ST_DONE. Clear, set enable, a dropped push and a pull that pops nothing
//   or a non-repeating task go straight there; a pull that pops a repeating
//   task also reads its enable bit in ST_ENA and, if that bit is clear, ends.
//   A push, and a pull that reschedules, insert the entry with a walk back
//   through the slot RAM port, one slot compared or shifted a cycle, over at
//   most the entries held after any pop, ending with a write in ST_WALK or
//   ST_PLACE. The result beat goes valid in the cycle ready returns high.
//   After reset the block sweeps the task enable RAM, one entry a cycle,
//   over all 2**TASK_ID_BITS entries (256 by default) before it takes a beat;
//   the queue starts empty and the last timestamp at zero.
//   When result_o stalls, one finished result waits in the output register
//   and the next command is still accepted; that command is held at its
//   end until the register frees.
// ----------------------------------------------------------------------------
module timed_task_schedule_queue
  import tts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = TTS_QUEUE_DEPTH,
  parameter int unsigned TASK_ID_BITS = TTS_ID_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tts_task_if.sink     task_in_i,
  tts_result_if.source result_o
);

  localparam int unsigned AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned SLOT_W = TIME_W + TASK_ID_BITS + DELAY_W + 1;
  localparam int unsigned ID_CNT = 2 ** TASK_ID_BITS;

  tu_req_t                 tu_req;
  tu_rsp_t                 tu_rsp;
  logic                    slot_we;
  logic [AW-1:0]           slot_waddr;
  logic [SLOT_W-1:0]       slot_wdata;
  logic [AW-1:0]           slot_raddr;
  logic [SLOT_W-1:0]       slot_rdata;
  logic                    en_we;
  logic [TASK_ID_BITS-1:0] en_waddr;
  logic                    en_wdata;
  logic [TASK_ID_BITS-1:0] en_raddr;
  logic                    en_rdata;

  // Sequencer
  tts_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .task_in_i   (task_in_i),
    .result_o    (result_o),
    .tu_req_o    (tu_req),
    .tu_rsp_i    (tu_rsp),
    .slot_we_o   (slot_we),
    .slot_waddr_o(slot_waddr),
    .slot_wdata_o(slot_wdata),
    .slot_raddr_o(slot_raddr),
    .slot_rdata_i(slot_rdata),
    .en_we_o     (en_we),
    .en_waddr_o  (en_waddr),
    .en_wdata_o  (en_wdata),
    .en_raddr_o  (en_raddr),
    .en_rdata_i  (en_rdata)
  );

  // Shared compare/add unit
  tts_time_unit u_time_unit (
    .req_i(tu_req),
    .rsp_o(tu_rsp)
  );

  // Sorted slots: due time, task, period, repeat flag
  tts_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  // Per-task enable bits
  tts_ram #(
    .WIDTH(1),
    .DEPTH(ID_CNT)
  ) u_enable_ram (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(en_waddr),
    .wdata_i(en_wdata),
    .raddr_i(en_raddr),
    .rdata_o(en_rdata)
  );

endmodule
